// ===== rtl/segment_pool_allocator_top_assert.svh =====
// Assertion macros used by the checker of the segment pool allocator.
`ifndef SEGMENT_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SEGMENT_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spa check failed");

// Next-cycle implication, held off while reset is asserted.
`define SPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spa check failed");

`endif

// ===== rtl/spa_pkg.sv =====
package spa_pkg;

  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned SEG_W = 65;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_MERGE = 2'd2;
  localparam logic [1:0] ACT_RESET = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic [1:0] CFG_FIT    = 2'd0;
  localparam logic [1:0] CFG_POOL   = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;

  typedef struct packed {
    logic        free;
    logic [31:0] len;
    logic [31:0] start;
  } seg_entry_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SPLIT_HI,
    S_WR_PICK,
    S_MERGE,
    S_DONE
  } spa_state_e;

endpackage

// ===== rtl/spa_ram.sv =====
module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/segment_pool_allocator_top.sv =====
// Segment pool allocator: one request at a time, one result per request.
// Allocate scans the table, then on a split shifts the entries above the pick up and writes
// the free remainder; free scans then writes; merge compacts; pool reset writes entry 0.
// The next request is accepted the cycle after the result is loaded; a
// held result stalls input. Reset: table entry 0 written as one free segment in the
// init state, counters clear, config returns to first fit, 1 MiB pool, 112-byte margin.
module segment_pool_allocator_top #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] block_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] grant_offset_o,
  output logic [31:0] granted_size_o,
  output logic [5:0]  merged_count_o,
  output logic [31:0] used_total_o,
  output logic [31:0] free_total_o,
  output logic [6:0]  segment_count_o
);
  import spa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  // configuration
  logic [1:0]  fit_q;
  logic [31:0] pool_q;
  logic [15:0] margin_q;

  // request being worked on
  spa_state_e  state_q, state_d;
  logic [1:0]  act_q, act_d;
  logic [32:0] need_q, need_d;
  logic [31:0] off_q, off_d;

  // pool bookkeeping
  logic [CW-1:0] used_q, used_d;
  logic          nf_valid_q, nf_valid_d;
  logic [31:0]   nf_off_q, nf_off_d;
  logic [31:0]   in_use_q, in_use_d;
  logic [31:0]   avail_q, avail_d;

  // table walk: read issue and the returning data
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] dv_idx_q, dv_idx_d;

  // candidates; "after" is the next-fit hit at or past the recorded start
  logic          pick_v_q, pick_v_d;
  logic [AW-1:0] pick_idx_q, pick_idx_d;
  seg_entry_t    pick_e_q, pick_e_d;
  logic          after_v_q, after_v_d;
  logic [AW-1:0] after_idx_q, after_idx_d;
  seg_entry_t    after_e_q, after_e_d;
  logic          from_found_q, from_found_d;
  logic [31:0]   fin_len_q, fin_len_d;

  // merge compaction: running segment and write pointer
  seg_entry_t    cur_e_q, cur_e_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [CW-1:0] mcnt_q, mcnt_d;

  // staged result and output register
  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_goff_q, res_goff_d;
  logic [31:0] res_gsize_q, res_gsize_d;
  logic [5:0]  res_merged_q, res_merged_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] goff_q, goff_d;
  logic [31:0] gsize_q, gsize_d;
  logic [5:0]  merged_q, merged_d;
  logic [31:0] used_tot_q, used_tot_d;
  logic [31:0] free_tot_q, free_tot_d;
  logic [6:0]  seg_cnt_q, seg_cnt_d;

  // table RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  seg_entry_t    ram_wdata, rd_e;
  logic [SEG_W-1:0] ram_rdata;

  spa_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_e = seg_entry_t'(ram_rdata);

  logic        in_acc;
  logic        issue_up, issue_down;
  logic        fit, nf_hit, split, join_ok;
  logic [32:0] round_sum;
  logic [31:0] mcnt32, used32;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign issue_up   = (rd_idx_q < used_q);
  assign issue_down = (rd_idx_q > CW'(pick_idx_q));
  assign round_sum  = {1'b0, req_size_i} + 33'(ALIGN_BYTES - 1);
  assign fit        = rd_e.free && ({1'b0, rd_e.len} >= need_q);
  assign nf_hit     = nf_valid_q && !from_found_q && (rd_e.start == nf_off_q);
  assign join_ok    = cur_e_q.free && rd_e.free &&
                      (({1'b0, cur_e_q.start} + {1'b0, cur_e_q.len}) == {1'b0, rd_e.start});
  assign mcnt32     = 32'(mcnt_q);
  assign used32     = 32'(used_q);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    need_d       = need_q;
    off_d        = off_q;
    used_d       = used_q;
    nf_valid_d   = nf_valid_q;
    nf_off_d     = nf_off_q;
    in_use_d     = in_use_q;
    avail_d      = avail_q;
    rd_idx_d     = rd_idx_q;
    dv_d         = 1'b0;
    dv_idx_d     = dv_idx_q;
    pick_v_d     = pick_v_q;
    pick_idx_d   = pick_idx_q;
    pick_e_d     = pick_e_q;
    after_v_d    = after_v_q;
    after_idx_d  = after_idx_q;
    after_e_d    = after_e_q;
    from_found_d = from_found_q;
    fin_len_d    = fin_len_q;
    cur_e_d      = cur_e_q;
    wr_idx_d     = wr_idx_q;
    mcnt_d       = mcnt_q;
    res_status_d = res_status_q;
    res_goff_d   = res_goff_q;
    res_gsize_d  = res_gsize_q;
    res_merged_d = res_merged_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    goff_d       = goff_q;
    gsize_d      = gsize_q;
    merged_d     = merged_q;
    used_tot_d   = used_tot_q;
    free_tot_d   = free_tot_q;
    seg_cnt_d    = seg_cnt_q;
    split        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = rd_idx_q[AW-1:0];

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{free: 1'b1, len: pool_q, start: 32'd0};
        state_d   = S_IDLE;
      end

      S_IDLE: begin
        if (in_acc) begin
          act_d        = action_i;
          need_d       = round_sum & ~33'(ALIGN_BYTES - 1);
          off_d        = block_offset_i;
          rd_idx_d     = '0;
          pick_v_d     = 1'b0;
          after_v_d    = 1'b0;
          from_found_d = 1'b0;
          wr_idx_d     = '0;
          mcnt_d       = '0;
          res_status_d = ST_OK;
          res_goff_d   = '0;
          res_gsize_d  = '0;
          res_merged_d = '0;
          unique case (action_i)
            ACT_ALLOC: begin
              if (req_size_i == 32'd0) begin
                res_status_d = ST_NOFIT;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_FREE:  state_d = S_SCAN;
            ACT_MERGE: state_d = S_MERGE;
            default: begin
              // pool reset request
              ram_we     = 1'b1;
              ram_wdata  = '{free: 1'b1, len: pool_q, start: 32'd0};
              used_d     = CW'(1);
              nf_valid_d = 1'b0;
              nf_off_d   = '0;
              in_use_d   = '0;
              avail_d    = pool_q;
              state_d    = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_up) begin
          dv_d     = 1'b1;
          dv_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (dv_q) begin
          if (act_q == ACT_FREE) begin
            if (!pick_v_q && (rd_e.start == off_q)) begin
              pick_v_d   = 1'b1;
              pick_idx_d = dv_idx_q;
              pick_e_d   = rd_e;
            end
          end else begin
            unique case (fit_q)
              FIT_FIRST: begin
                if (fit && !pick_v_q) begin
                  pick_v_d = 1'b1; pick_idx_d = dv_idx_q; pick_e_d = rd_e;
                end
              end
              FIT_BEST: begin
                if (fit && (!pick_v_q || rd_e.len < pick_e_q.len)) begin
                  pick_v_d = 1'b1; pick_idx_d = dv_idx_q; pick_e_d = rd_e;
                end
              end
              FIT_WORST: begin
                if (fit && (!pick_v_q || rd_e.len > pick_e_q.len)) begin
                  pick_v_d = 1'b1; pick_idx_d = dv_idx_q; pick_e_d = rd_e;
                end
              end
              default: begin
                if (nf_hit) begin
                  from_found_d = 1'b1;
                end
                if (fit && !pick_v_q) begin
                  pick_v_d = 1'b1; pick_idx_d = dv_idx_q; pick_e_d = rd_e;
                end
                if (fit && (from_found_q || nf_hit) && !after_v_q) begin
                  after_v_d = 1'b1; after_idx_d = dv_idx_q; after_e_d = rd_e;
                end
              end
            endcase
          end
        end
        if (!issue_up && !dv_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d = S_DONE;
        if (act_q == ACT_FREE) begin
          if (!pick_v_q) begin
            res_status_d = ST_UNKNOWN;
          end else if (pick_e_q.free) begin
            res_status_d = ST_DOUBLE;
          end else begin
            ram_we      = 1'b1;
            ram_waddr   = pick_idx_q;
            ram_wdata   = '{free: 1'b1, len: pick_e_q.len, start: pick_e_q.start};
            in_use_d    = in_use_q - pick_e_q.len;
            avail_d     = avail_q + pick_e_q.len;
            res_gsize_d = pick_e_q.len;
          end
        end else if (!pick_v_q) begin
          res_status_d = ST_NOFIT;
        end else begin
          // next fit prefers a hit at or after the recorded start, else wraps
          if (fit_q == FIT_NEXT && from_found_q && after_v_q) begin
            pick_idx_d = after_idx_q;
            pick_e_d   = after_e_q;
            split = ({2'b0, after_e_q.len} >= ({1'b0, need_q} + 34'(margin_q)));
          end else begin
            split = ({2'b0, pick_e_q.len} >= ({1'b0, need_q} + 34'(margin_q)));
          end
          split = split && (used_q < CW'(MAX_SEGMENTS));
          if (split) begin
            fin_len_d = need_q[31:0];
            rd_idx_d  = used_q - CW'(1);
            state_d   = S_SHIFT;
          end else begin
            fin_len_d = pick_e_d.len;
            state_d   = S_WR_PICK;
          end
        end
      end

      S_SHIFT: begin
        // move entries above the split point up by one, top first
        if (issue_down) begin
          dv_d     = 1'b1;
          dv_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d = rd_idx_q - CW'(1);
        end
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = dv_idx_q + AW'(1);
          ram_wdata = rd_e;
        end
        if (!issue_down && !dv_q) begin
          state_d = S_SPLIT_HI;
        end
      end

      S_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = pick_idx_q + AW'(1);
        ram_wdata = '{free:  1'b1,
                      len:   pick_e_q.len - need_q[31:0],
                      start: pick_e_q.start + need_q[31:0]};
        used_d    = used_q + CW'(1);
        state_d   = S_WR_PICK;
      end

      S_WR_PICK: begin
        ram_we      = 1'b1;
        ram_waddr   = pick_idx_q;
        ram_wdata   = '{free: 1'b0, len: fin_len_q, start: pick_e_q.start};
        in_use_d    = in_use_q + fin_len_q;
        avail_d     = avail_q - fin_len_q;
        nf_valid_d  = 1'b1;
        nf_off_d    = pick_e_q.start;
        res_goff_d  = pick_e_q.start;
        res_gsize_d = fin_len_q;
        state_d     = S_DONE;
      end

      S_MERGE: begin
        if (issue_up) begin
          dv_d     = 1'b1;
          dv_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (dv_q) begin
          if (dv_idx_q == '0) begin
            cur_e_d = rd_e;
          end else if (join_ok) begin
            cur_e_d.len = cur_e_q.len + rd_e.len;
            mcnt_d      = mcnt_q + CW'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_idx_q;
            ram_wdata = cur_e_q;
            wr_idx_d  = wr_idx_q + AW'(1);
            cur_e_d   = rd_e;
          end
        end
        if (!issue_up && !dv_q) begin
          ram_we       = 1'b1;
          ram_waddr    = wr_idx_q;
          ram_wdata    = cur_e_q;
          used_d       = CW'(wr_idx_q) + CW'(1);
          res_merged_d = (mcnt32 > 32'd63) ? 6'd63 : mcnt32[5:0];
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          goff_d      = res_goff_q;
          gsize_d     = res_gsize_q;
          merged_d    = res_merged_q;
          used_tot_d  = in_use_q;
          free_tot_d  = avail_q;
          seg_cnt_d   = used32[6:0];
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q    <= FIT_FIRST;
      pool_q   <= 32'd1048576;
      margin_q <= 16'd112;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIT:    fit_q    <= cfg_data_i[1:0];
        CFG_POOL:   pool_q   <= cfg_data_i;
        CFG_MARGIN: margin_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      used_q      <= CW'(1);
      nf_valid_q  <= 1'b0;
      in_use_q    <= '0;
      avail_q     <= 32'd1048576;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      nf_valid_q  <= nf_valid_d;
      in_use_q    <= in_use_d;
      avail_q     <= avail_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    need_q       <= need_d;
    off_q        <= off_d;
    nf_off_q     <= nf_off_d;
    rd_idx_q     <= rd_idx_d;
    dv_idx_q     <= dv_idx_d;
    pick_v_q     <= pick_v_d;
    pick_idx_q   <= pick_idx_d;
    pick_e_q     <= pick_e_d;
    after_v_q    <= after_v_d;
    after_idx_q  <= after_idx_d;
    after_e_q    <= after_e_d;
    from_found_q <= from_found_d;
    fin_len_q    <= fin_len_d;
    cur_e_q      <= cur_e_d;
    wr_idx_q     <= wr_idx_d;
    mcnt_q       <= mcnt_d;
    res_status_q <= res_status_d;
    res_goff_q   <= res_goff_d;
    res_gsize_q  <= res_gsize_d;
    res_merged_q <= res_merged_d;
    status_q     <= status_d;
    goff_q       <= goff_d;
    gsize_q      <= gsize_d;
    merged_q     <= merged_d;
    used_tot_q   <= used_tot_d;
    free_tot_q   <= free_tot_d;
    seg_cnt_q    <= seg_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign grant_offset_o  = goff_q;
  assign granted_size_o  = gsize_q;
  assign merged_count_o  = merged_q;
  assign used_total_o    = used_tot_q;
  assign free_total_o    = free_tot_q;
  assign segment_count_o = seg_cnt_q;

endmodule

// ===== rtl/spa_checker.sv =====
`include "segment_pool_allocator_top_assert.svh"

module spa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic [1:0]  status_i,
  input logic [31:0] grant_offset_i,
  input logic [31:0] granted_size_i,
  input logic [5:0]  merged_count_i,
  input logic [6:0]  segment_count_i
);
  import spa_pkg::*;

  // the table always holds at least one segment
  `SPA_ASSERT_IMP(a_seg_nonzero, clk_i, rst_ni, out_valid_i, segment_count_i != 7'd0)
  // failed requests carry no grant
  `SPA_ASSERT_IMP(a_fail_no_grant, clk_i, rst_ni, out_valid_i && status_i != ST_OK,
                  grant_offset_i == 32'd0 && granted_size_i == 32'd0)
  // only a successful merge reports absorbed segments
  `SPA_ASSERT_IMP(a_merge_ok, clk_i, rst_ni, out_valid_i && merged_count_i != 6'd0,
                  status_i == ST_OK)
  // one request at a time: busy right after an accept
  `SPA_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i)

endmodule

bind segment_pool_allocator_top spa_checker u_spa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .status_i        (status_o),
  .grant_offset_i  (grant_offset_o),
  .granted_size_i  (granted_size_o),
  .merged_count_i  (merged_count_o),
  .segment_count_i (segment_count_o)
);

// ===== test/spa_checker.sv =====
module spa_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] block_offset_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] grant_offset_i,
  input  logic [31:0] granted_size_i,
  input  logic [5:0]  merged_count_i,
  input  logic [31:0] used_total_i,
  input  logic [31:0] free_total_i,
  input  logic [6:0]  segment_count_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam int NSEG = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_offset;
    logic [31:0] granted_size;
    logic [5:0]  merged_count;
    logic [31:0] used_total;
    logic [31:0] free_total;
    logic [6:0]  segment_count;
  } pool_result_t;

  pool_result_t expected_grants[$];

  // shadow of the pool table and registers
  logic [31:0] seg_base[NSEG];
  logic [31:0] seg_len[NSEG];
  bit          seg_free[NSEG];
  int          seg_cnt;
  bit          nf_valid;
  logic [31:0] nf_base;
  logic [31:0] bytes_used;
  logic [31:0] bytes_free;
  logic [1:0]  fit_mode;
  logic [31:0] pool_size;
  logic [15:0] margin;

  function automatic void restart_pool();
    for (int k = 0; k < NSEG; k++) begin
      seg_base[k] = '0;
      seg_len[k]  = '0;
      seg_free[k] = 1'b0;
    end
    seg_len[0]  = pool_size;
    seg_free[0] = 1'b1;
    seg_cnt     = 1;
    nf_valid    = 1'b0;
    nf_base     = '0;
    bytes_used  = '0;
    bytes_free  = pool_size;
  endfunction

  function automatic bit can_hold(int k, logic [32:0] need);
    return seg_free[k] && ({1'b0, seg_len[k]} >= need);
  endfunction

  // index of the chosen segment, NSEG when nothing fits
  function automatic int pick_segment(logic [32:0] need);
    int pick;
    int from;
    pick = NSEG;
    from = 0;
    case (fit_mode)
      FIT_BEST, FIT_WORST: begin
        for (int k = 0; k < seg_cnt; k++) begin
          if (can_hold(k, need) && (pick == NSEG ||
              (fit_mode == FIT_BEST ? seg_len[k] < seg_len[pick]
                                    : seg_len[k] > seg_len[pick])))
            pick = k;
        end
        return pick;
      end
      FIT_NEXT: begin
        if (nf_valid) begin
          for (int k = 0; k < seg_cnt; k++) begin
            if (seg_base[k] == nf_base) begin
              from = k;
              break;
            end
          end
        end
        for (int k = from; k < seg_cnt; k++) if (can_hold(k, need)) return k;
        for (int k = 0; k < from; k++) if (can_hold(k, need)) return k;
        return NSEG;
      end
      default: begin
        for (int k = 0; k < seg_cnt; k++) if (can_hold(k, need)) return k;
        return NSEG;
      end
    endcase
  endfunction

  function automatic pool_result_t apply_pool_request(logic [1:0] act, logic [31:0] size,
                                                      logic [31:0] offset);
    pool_result_t r;
    logic [32:0] need;
    int          pick;
    int          k;
    r = '0;
    case (act)
      ACT_ALLOC: begin
        need = ({1'b0, size} + 33'd7) & ~33'd7;
        pick = (size == 0) ? NSEG : pick_segment(need);
        if (pick >= NSEG) begin
          r.status = ST_NOFIT;
        end else begin
          if ({32'd0, seg_len[pick]} >= {31'd0, need} + {48'd0, margin} && seg_cnt < NSEG)
          begin
            for (int j = seg_cnt; j > pick + 1; j--) begin
              seg_base[j] = seg_base[j-1];
              seg_len[j]  = seg_len[j-1];
              seg_free[j] = seg_free[j-1];
            end
            seg_base[pick+1] = seg_base[pick] + need[31:0];
            seg_len[pick+1]  = seg_len[pick] - need[31:0];
            seg_free[pick+1] = 1'b1;
            seg_len[pick]    = need[31:0];
            seg_cnt++;
          end
          seg_free[pick] = 1'b0;
          bytes_used += seg_len[pick];
          bytes_free -= seg_len[pick];
          nf_valid = 1'b1;
          nf_base  = seg_base[pick];
          r.grant_offset = seg_base[pick];
          r.granted_size = seg_len[pick];
        end
      end
      ACT_FREE: begin
        r.status = ST_UNKNOWN;
        for (int j = 0; j < seg_cnt; j++) begin
          if (seg_base[j] == offset) begin
            if (seg_free[j]) begin
              r.status = ST_DOUBLE;
            end else begin
              r.status = ST_OK;
              seg_free[j] = 1'b1;
              bytes_used -= seg_len[j];
              bytes_free += seg_len[j];
              r.granted_size = seg_len[j];
            end
            break;
          end
        end
      end
      ACT_MERGE: begin
        k = 0;
        while (k + 1 < seg_cnt) begin
          if (seg_free[k] && seg_free[k+1] &&
              {1'b0, seg_base[k]} + {1'b0, seg_len[k]} == {1'b0, seg_base[k+1]}) begin
            seg_len[k] = seg_len[k] + seg_len[k+1];
            for (int j = k + 1; j + 1 < seg_cnt; j++) begin
              seg_base[j] = seg_base[j+1];
              seg_len[j]  = seg_len[j+1];
              seg_free[j] = seg_free[j+1];
            end
            seg_cnt--;
            seg_base[seg_cnt] = '0;
            seg_len[seg_cnt]  = '0;
            seg_free[seg_cnt] = 1'b0;
            if (r.merged_count != 6'd63) r.merged_count++;
            continue;
          end
          k++;
        end
      end
      default: restart_pool();
    endcase
    r.used_total    = bytes_used;
    r.free_total    = bytes_free;
    r.segment_count = seg_cnt[6:0];
    return r;
  endfunction

  function automatic int field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t e;
    int ok;
    if (!rst_ni) begin
      fit_mode  = FIT_FIRST;
      pool_size = 32'd1048576;
      margin    = 16'd112;
      restart_pool();
      expected_grants.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIT:    fit_mode  = cfg_data_i[1:0];
          CFG_POOL:   pool_size = cfg_data_i;
          CFG_MARGIN: margin    = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result, status %h", $time, status_i);
          errors_o <= errors_o + 1;
        end else begin
          e  = expected_grants.pop_front();
          ok = field_ok("status", e.status, status_i)
             & field_ok("grant_offset", e.grant_offset, grant_offset_i)
             & field_ok("granted_size", e.granted_size, granted_size_i)
             & field_ok("merged_count", e.merged_count, merged_count_i)
             & field_ok("used_total", e.used_total, used_total_i)
             & field_ok("free_total", e.free_total, free_total_i)
             & field_ok("segment_count", e.segment_count, segment_count_i);
          if (!ok) errors_o <= errors_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_grants.push_back(apply_pool_request(action_i, req_size_i, block_offset_i));
      pending_o <= expected_grants.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_FIT;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_ALLOC;
  logic [31:0] req_size = '0;
  logic [31:0] block_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] grant_offset, granted_size, used_total, free_total;
  logic [5:0]  merged_count;
  logic [6:0]  segment_count;
  int          errors, pending;

  // idle percentages, changed by the stimulus as the run moves on
  int tx_idle = 24;
  int rx_idle = 70;
  // long receiver hold-off, requested by bumping hold_reqs
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // offsets currently handed out, learned from the results
  logic [31:0] live_offsets[$];
  logic [1:0]  sent_actions[$];

  always #5 clk_i = ~clk_i;

  segment_pool_allocator_top u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .req_size_i(req_size), .block_offset_i(block_offset),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .grant_offset_o(grant_offset), .granted_size_o(granted_size),
    .merged_count_o(merged_count), .used_total_o(used_total), .free_total_o(free_total),
    .segment_count_o(segment_count)
  );

  spa_scoreboard u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .req_size_i(req_size), .block_offset_i(block_offset),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .grant_offset_i(grant_offset), .granted_size_i(granted_size),
    .merged_count_i(merged_count), .used_total_i(used_total), .free_total_i(free_total),
    .segment_count_i(segment_count),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: random stall, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cnt  <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // track live grants so frees mostly hit real segments; watchdog
  always @(posedge clk_i) begin
    logic [1:0] a;
    if (rst_ni) begin
      if (in_valid && !in_stall) sent_actions.push_back(action);
      if (out_valid && !out_stall && sent_actions.size() != 0) begin
        a = sent_actions.pop_front();
        if (a == ACT_ALLOC && status == ST_OK) live_offsets.push_back(grant_offset);
        if (a == ACT_RESET) live_offsets.delete();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("segment_pool_allocator_top: mismatch");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] a, input logic [31:0] sz, input logic [31:0] off);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 60);
    end
    in_valid     <= 1'b1;
    action       <= a;
    req_size     <= sz;
    block_offset <= off;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // sender pause: let every outstanding result come back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(19))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return $urandom_range(1, 65536);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  // one random request; frees mostly target a segment handed out earlier
  task automatic random_request();
    int          r;
    int          k;
    logic [31:0] off;
    r = $urandom_range(99);
    if (r < 48) begin
      send(ACT_ALLOC, pick_size(), $urandom);
    end else if (r < 85) begin
      if (live_offsets.size() != 0 && $urandom_range(9) != 0) begin
        k   = $urandom_range(live_offsets.size() - 1);
        off = live_offsets[k];
        live_offsets.delete(k);
      end else begin
        off = ($urandom_range(1) != 0) ? $urandom : ($urandom_range(4096) & ~32'd7);
      end
      send(ACT_FREE, $urandom, off);
    end else if (r < 97) begin
      send(ACT_MERGE, $urandom, $urandom);
    end else begin
      send(ACT_RESET, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] pools[6];
    logic [15:0] margins[6];
    int          n;
    pools   = '{32'd4096, 32'd8, 32'hFFFF_FFFF, 32'd1048576, 32'd65536, 32'd2048};
    margins = '{16'd0, 16'd112, 16'hFFFF, 16'd0, 16'd32, 16'd8};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, first fit, 1 MiB pool
    send(ACT_ALLOC, 32'd0, 32'd0);             // zero size
    send(ACT_ALLOC, 32'd1, 32'hFFFF_FFFF);     // rounds to 8, lands at 0
    send(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);     // oversized
    send(ACT_ALLOC, 32'd8, 32'd0);
    send(ACT_FREE, 32'hFFFF_FFFF, 32'd0);
    send(ACT_FREE, 32'd0, 32'd0);              // double free
    send(ACT_FREE, 32'd0, 32'd12345);          // unknown offset
    send(ACT_FREE, 32'd0, 32'hFFFF_FFFF);
    send(ACT_MERGE, 32'd0, 32'd0);
    send(ACT_RESET, 32'd0, 32'd0);
    drain();

    // tiny pool: exact fit then no fit
    write_reg(CFG_POOL, 32'd8);
    write_reg(CFG_MARGIN, 32'h0000_FFFF);
    send(ACT_RESET, 32'd0, 32'd0);
    send(ACT_ALLOC, 32'd8, 32'd0);
    send(ACT_ALLOC, 32'd1, 32'd0);
    drain();

    // full-range pool, best fit, near-full grant then a size that rounds past 32 bits
    write_reg(CFG_POOL, 32'hFFFF_FFFF);
    write_reg(CFG_MARGIN, 32'd0);
    write_reg(CFG_FIT, FIT_BEST);
    send(ACT_RESET, 32'd0, 32'd0);
    send(ACT_ALLOC, 32'hFFFF_FFF8, 32'd0);
    send(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
    drain();

    // next fit with a start that a merge has removed
    write_reg(CFG_POOL, 32'd4096);
    write_reg(CFG_FIT, FIT_NEXT);
    send(ACT_RESET, 32'd0, 32'd0);
    send(ACT_ALLOC, 32'd8, 32'd0);
    send(ACT_ALLOC, 32'd8, 32'd0);
    send(ACT_FREE, 32'd0, 32'd8);
    send(ACT_FREE, 32'd0, 32'd0);
    send(ACT_MERGE, 32'd0, 32'd0);
    send(ACT_ALLOC, 32'd16, 32'd0);
    drain();

    // random phases, each with its own register setting
    n = 0;
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_FIT, p[1:0]);
      write_reg(CFG_POOL, (p == 5) ? ($urandom | 32'd8) : pools[p]);
      write_reg(CFG_MARGIN, (p == 4) ? 32'($urandom_range(65535)) : {16'd0, margins[p]});
      send(ACT_RESET, $urandom, $urandom);
      // fill the table with small grants on the zero-margin phases
      if (margins[p] == 0) begin
        for (int k = 0; k < 70; k++) send(ACT_ALLOC, $urandom_range(1, 16), $urandom);
        n += 70;
      end
      if (p == 2) hold_reqs++;   // receiver holds off while requests keep coming
      for (int k = 0; k < 55; k++) begin
        n++;
        if (n == 250) begin
          tx_idle = 70;
          rx_idle = 24;
        end
        random_request();
      end
      drain();
    end
    // no idling on either side for the last stretch
    tx_idle = 0;
    rx_idle = 0;
    for (int k = 0; k < 250; k++) random_request();
    drain();

    if (errors == 0)
      $display("segment_pool_allocator_top: match");
    else
      $display("segment_pool_allocator_top: mismatch");
    $finish;
  end

endmodule
